### hdl/wsts_pkg.sv
// Package for the work-stealing task scheduler: status codes, backoff limits, operations,
// register address, FSM states. No dependencies.
package wsts_pkg;
  localparam logic [2:0] ST_PUSHED = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_OWN    = 3'd2;
  localparam logic [2:0] ST_STOLEN = 3'd3;
  localparam logic [2:0] ST_NONE   = 3'd4;
  localparam logic [20:0] BACKOFF_START = 21'd100;
  localparam logic [20:0] BACKOFF_CAP   = 21'd1000000;

  // request operations
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // register byte addresses
  localparam logic [1:0] ADDR_ACTIVE_WORKERS = 2'd0;

  typedef enum logic [2:0] {
    S_IDLE, S_OWN, S_STEAL, S_READ, S_DONE, S_OUT
  } state_t;
endpackage

### hdl/work_stealing_task_scheduler.sv
// Top level of the work-stealing task scheduler: sequencer, index tables, backoff.
// Depends on wsts_pkg and wsts_ram.
//
//  channel | ports                              | direction
//  in      | in_valid/in_stall + 4 fields       | request in
//  out     | out_valid/out_stall + 4 fields     | result out
//  cfg     | cfg_psel..cfg_pready               | APB register access
//
// A push passes from the idle cycle that takes the transfer through OWN, READ, DONE
// and OUT. A fetch probes one deque per cycle, own deques first from priority 0 up.
// A steal first takes the remainder for the scan start (one 2-bit digit per cycle),
// then probes one deque per cycle; a hit goes on through READ, DONE and OUT.
// Reset is synchronous; deque storage is not cleared. A stalled result holds the
// block; no new transfer is taken meanwhile.
module work_stealing_task_scheduler #(
  parameter int WORKERS     = 4,
  parameter int PRIORITIES  = 3,
  parameter int DEQUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [1:0]  in_worker,
  input  logic [1:0]  in_priority_req,
  input  logic [15:0] in_task_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_found_task,
  output logic [1:0]  out_victim,
  output logic [20:0] out_wait_ns,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import wsts_pkg::*;

  localparam int NDEQ = WORKERS * PRIORITIES;
  localparam int IW   = $clog2(DEQUE_DEPTH) + 1;   // index counts mod 2*depth
  localparam int DW   = $clog2(DEQUE_DEPTH);
  localparam int QW   = (NDEQ > 1) ? $clog2(NDEQ) : 1;
  localparam int PW   = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
  localparam int WW   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int AW   = $clog2(NDEQ * DEQUE_DEPTH);
  localparam int CW   = $clog2(WORKERS + 1);

  // config
  logic [2:0] active_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {29'd0, active_r};
  always_ff @(posedge clk) begin
    if (!rst_n) active_r <= 3'd4;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_ACTIVE_WORKERS)
      active_r <= cfg_pwdata[2:0];
  end

  // clamped worker count
  logic [CW-1:0] wc;
  always_comb begin
    if (active_r == 3'd0) wc = CW'(1);
    else if (32'(active_r) > WORKERS) wc = CW'(WORKERS);
    else wc = CW'(active_r);
  end

  logic [IW-1:0] top_r [NDEQ];
  logic [IW-1:0] bot_r [NDEQ];
  logic [31:0]   fail_r [WORKERS];
  logic [20:0]   boff_r [WORKERS];

  state_t state_r, state_nxt;
  logic        op_r;
  logic [1:0]  w_r;
  logic [1:0]  pr_r;
  logic [15:0] tid_r;
  logic [PW-1:0] p_r;           // priority being probed
  logic [CW-1:0] v_r;           // victim being probed
  logic [CW-1:0] i_r;           // scan steps done
  logic [2:0]  st_r;
  logic [1:0]  vic_r;
  logic [20:0] wait_r;
  logic [15:0] found_r;

  // one deque probe per cycle
  logic [WW-1:0] probe_w;
  logic [QW-1:0] q;
  logic [IW-1:0] occ;
  logic          w_ok;
  assign w_ok    = 32'(w_r) < WORKERS;
  assign probe_w = (state_r == S_STEAL) ? WW'(v_r) : WW'(w_r);
  assign q       = QW'(32'(probe_w) * PRIORITIES + 32'(p_r));
  assign occ     = bot_r[q] - top_r[q];

  logic          ram_we;
  logic [AW-1:0] ram_addr, ram_addr_r;
  logic [15:0]   ram_rd;
  wsts_ram #(.WIDTH(16), .DEPTH(NDEQ * DEQUE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(tid_r), .rdata(ram_rd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_found_task = found_r;
  assign out_victim = vic_r;
  assign out_wait_ns = wait_r;

  // steal scan: position i maps to (start+i) mod wc
  logic [CW-1:0] v_inc;
  assign v_inc = (v_r + CW'(1) >= wc) ? CW'(0) : v_r + CW'(1);
  logic last_p;
  assign last_p = (32'(p_r) == PRIORITIES - 1);

  // start = (w + fail + 1) mod wc, 32-bit wrap; remainder taken MSB digit first,
  // two bits per cycle, by a compare-and-subtract of 2*wc then wc
  logic [31:0]   sum_s;
  assign sum_s = 32'(w_r) + fail_r[w_r[WW-1:0]] + 32'd1;
  logic [31:0]   dvd_r;
  logic [CW-1:0] rem_r;
  logic [3:0]    dig_r;
  logic          modding_r;
  logic [CW+1:0] mod_t, mod_a, mod_b, wc_x1, wc_x2;
  assign wc_x1 = (CW+2)'(wc);
  assign wc_x2 = (CW+2)'({wc, 1'b0});
  assign mod_t = {rem_r, dvd_r[31:30]};
  assign mod_a = (mod_t >= wc_x2) ? mod_t - wc_x2 : mod_t;
  assign mod_b = (mod_a >= wc_x1) ? mod_a - wc_x1 : mod_a;

  logic own_hit, steal_hit;
  assign own_hit   = (occ != '0);
  assign steal_hit = (occ != '0) && (v_r != CW'(w_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_OWN;
      S_OWN: begin
        if (op_r == OP_PUSH) state_nxt = S_READ;
        else if (!w_ok) state_nxt = S_DONE;
        else if (own_hit) state_nxt = S_READ;
        else if (last_p) state_nxt = S_STEAL;
      end
      S_STEAL: begin
        if (modding_r) state_nxt = S_STEAL;
        else if (i_r + CW'(1) >= wc) state_nxt = S_DONE;
        else if (steal_hit) state_nxt = S_READ;
      end
      S_READ:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // push write happens in S_DONE using the latched address
  logic push_wr;
  assign push_wr = (state_r == S_DONE) && (op_r == OP_PUSH) && (st_r == ST_PUSHED);

  // ram access address
  logic [IW-1:0] slot;
  always_comb begin
    ram_we = push_wr;
    slot = bot_r[q];
    if (state_r == S_OWN && op_r == OP_FETCH) slot = bot_r[q] - IW'(1);
    if (state_r == S_STEAL) slot = top_r[q];
    ram_addr = AW'(32'(q) * DEQUE_DEPTH + 32'(slot[DW-1:0]));
    if ((state_r == S_READ && op_r == OP_FETCH) || push_wr) ram_addr = ram_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      modding_r <= 1'b0;
      for (int k = 0; k < NDEQ; k++) begin
        top_r[k] <= '0;
        bot_r[k] <= '0;
      end
      for (int k = 0; k < WORKERS; k++) begin
        fail_r[k] <= '0;
        boff_r[k] <= BACKOFF_START;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_operation; w_r <= in_worker; pr_r <= in_priority_req;
          tid_r <= in_task_id; p_r <= '0; i_r <= '0;
          st_r <= ST_NONE; vic_r <= '0; wait_r <= '0; found_r <= '0;
        end
        S_OWN: begin
          if (op_r == OP_PUSH) begin
            // push: reuse probe on (w, pr)
            p_r <= PW'(pr_r);
          end else if (w_ok) begin
            if (own_hit) begin
              ram_addr_r <= ram_addr;
              st_r <= ST_OWN; vic_r <= w_r;
              if (occ == IW'(1)) top_r[q] <= top_r[q] + IW'(1);
              else bot_r[q] <= bot_r[q] - IW'(1);
            end else if (last_p) begin
              p_r <= '0; dvd_r <= sum_s; rem_r <= '0; dig_r <= '0;
              modding_r <= 1'b1;
            end else p_r <= p_r + PW'(1);
          end
        end
        S_STEAL: begin
          if (modding_r) begin
            rem_r <= mod_b[CW-1:0];
            dvd_r <= {dvd_r[29:0], 2'b00};
            dig_r <= dig_r + 4'd1;
            if (dig_r == 4'd15) begin
              modding_r <= 1'b0; v_r <= mod_b[CW-1:0];
            end
          end else if (i_r + CW'(1) < wc) begin
            if (steal_hit) begin
              ram_addr_r <= ram_addr;
              st_r <= ST_STOLEN; vic_r <= 2'(v_r);
              top_r[q] <= top_r[q] + IW'(1);
            end else if (last_p || v_r == CW'(w_r)) begin
              p_r <= '0; v_r <= v_inc; i_r <= i_r + CW'(1);
            end else p_r <= p_r + PW'(1);
          end
        end
        S_READ: begin
          if (op_r == OP_PUSH) begin
            // push decision (probe used p_r = pr)
            if (32'(pr_r) >= PRIORITIES || !w_ok || occ >= IW'(DEQUE_DEPTH))
              st_r <= ST_FULL;
            else begin
              ram_addr_r <= ram_addr;
              bot_r[q] <= bot_r[q] + IW'(1);
              st_r <= ST_PUSHED;
            end
          end
        end
        S_DONE: begin
          if (op_r == OP_FETCH && w_ok) begin
            if (st_r == ST_OWN || st_r == ST_STOLEN) begin
              found_r <= ram_rd;
              fail_r[w_r[WW-1:0]] <= '0;
              boff_r[w_r[WW-1:0]] <= BACKOFF_START;
            end else begin
              fail_r[w_r[WW-1:0]] <= fail_r[w_r[WW-1:0]] + 32'd1;
              if (fail_r[w_r[WW-1:0]] + 32'd1 > 32'(wc) * 32'd2) begin
                wait_r <= boff_r[w_r[WW-1:0]];
                boff_r[w_r[WW-1:0]] <= (boff_r[w_r[WW-1:0]] < BACKOFF_CAP)
                  ? {boff_r[w_r[WW-1:0]][19:0], 1'b0} : BACKOFF_CAP;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### hdl/wsts_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module wsts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### verif/work_stealing_task_scheduler_test.sv
// Testbench for work_stealing_task_scheduler: directed table, then random pushes and fetches.
// Results are checked against an in-bench predictor or a typed row's hand-written result.
// Depends on wsts_pkg and the scheduler RTL.
module work_stealing_task_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wsts_pkg::*;

  localparam int NW = 4;
  localparam int NP = 3;
  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;   // settle time after the last result

  typedef struct packed {
    logic        op;
    logic [1:0]  worker;
    logic [1:0]  prio;
    logic [15:0] task_id;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] task_id;
    logic [1:0]  victim;
    logic [20:0] wait_ns;
  } sched_result_t;

  // directed stimulus row; typed rows carry a hand-written result
  typedef struct {
    request_t      req;
    bit            typed;
    sched_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [1:0]  in_worker = '0;
  logic [1:0]  in_priority_req = '0;
  logic [15:0] in_task_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_found_task;
  logic [1:0]  out_victim;
  logic [20:0] out_wait_ns;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  work_stealing_task_scheduler DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: one ring per (worker, priority), 9-bit indexes wrap mod 512
  // ---------------------------------------------------------------------------
  logic [15:0] ring_mem [NW*NP][DEPTH];
  logic [8:0]  ring_top [NW*NP];
  logic [8:0]  ring_bot [NW*NP];
  logic [31:0] fail_count [NW];
  logic [31:0] wait_step [NW];
  logic [2:0]  active_reg;

  sched_result_t pending_results[$];
  int mismatches = 0;
  bit idling_on = 1'b1;

  function automatic logic [8:0] ring_fill(int q);
    return ring_bot[q] - ring_top[q];
  endfunction

  function automatic int tasks_queued();
    int n;
    n = 0;
    for (int q = 0; q < NW*NP; q++) n += ring_fill(q);
    return n;
  endfunction

  function automatic sched_result_t sched_predict(request_t r);
    sched_result_t res;
    int q, wc, v;
    logic [31:0] start;
    bit got;
    logic [15:0] t;
    res = '0;
    got = 1'b0;
    t = '0;
    if (r.op == OP_PUSH) begin
      if (r.prio >= NP) begin
        res.status = ST_FULL;
      end else begin
        q = r.worker * NP + r.prio;
        if (ring_fill(q) >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ring_mem[q][ring_bot[q][7:0]] = r.task_id;
          ring_bot[q] = ring_bot[q] + 1;
          res.status = ST_PUSHED;
        end
      end
      return res;
    end
    // fetch: clamp the worker count
    wc = active_reg;
    if (wc < 1) wc = 1;
    if (wc > NW) wc = NW;
    res.status = ST_NONE;
    // own deques from the bottom, highest priority first
    for (int p = 0; p < NP && !got; p++) begin
      q = r.worker * NP + p;
      if (ring_fill(q) != 0) begin
        t = ring_mem[q][(ring_bot[q] - 9'd1) & 9'hff];
        // last element leaves by the top
        if (ring_fill(q) == 1) ring_top[q] = ring_top[q] + 1;
        else ring_bot[q] = ring_bot[q] - 1;
        got = 1'b1;
        res.status = ST_OWN;
        res.victim = r.worker;
      end
    end
    if (!got) begin
      start = (32'(r.worker) + fail_count[r.worker] + 32'd1) % 32'(wc);
      for (int i = 0; i + 1 < wc && !got; i++) begin
        v = (start + i) % wc;
        if (v != r.worker) begin
          for (int p = 0; p < NP && !got; p++) begin
            q = v * NP + p;
            if (ring_fill(q) != 0) begin
              t = ring_mem[q][ring_top[q][7:0]];
              ring_top[q] = ring_top[q] + 1;
              got = 1'b1;
              res.status = ST_STOLEN;
              res.victim = v;
            end
          end
        end
      end
    end
    if (got) begin
      res.task_id = t;
      fail_count[r.worker] = '0;
      wait_step[r.worker] = BACKOFF_START;
    end else begin
      fail_count[r.worker] = fail_count[r.worker] + 1;
      if (fail_count[r.worker] > 32'(wc * 2)) begin
        res.wait_ns = wait_step[r.worker][20:0];
        if (wait_step[r.worker] < BACKOFF_CAP) wait_step[r.worker] = wait_step[r.worker] * 2;
        else wait_step[r.worker] = BACKOFF_CAP;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optional idle burst, then hold the request until it transfers
  // ---------------------------------------------------------------------------
  task automatic issue_request(request_t r, bit typed, sched_result_t typed_res);
    sched_result_t pred;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= r.op;
    in_worker       <= r.worker;
    in_priority_req <= r.prio;
    in_task_id      <= r.task_id;
    do @(posedge clk); while (in_stall);
    pred = sched_predict(r);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic random_request(int push_pct);
    request_t r;
    r.op      = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_FETCH;
    r.worker  = $urandom_range(0, 3);
    r.prio    = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    r.task_id = $urandom_range(0, 65535);
    issue_request(r, 1'b0, '0);
  endtask

  // waits out every expected result, then lets the block settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write then read-back of the worker-count register
  task automatic write_active_workers(logic [2:0] val);
    wait_quiet();
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= ADDR_ACTIVE_WORKERS;
    cfg_pwdata <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    active_reg = val;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[2:0] !== val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("cfg readback: expected %0d got %0d", val, cfg_prdata[2:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall bursts
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: every transfer against the oldest expectation
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer, status %0d", out_status);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status || out_found_task !== exp_r.task_id ||
            out_victim !== exp_r.victim || out_wait_ns !== exp_r.wait_ns) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp st=%0d task=%h vic=%0d wait=%0d, got st=%0d task=%h vic=%0d wait=%0d",
                     exp_r.status, exp_r.task_id, exp_r.victim, exp_r.wait_ns,
                     out_status, out_found_task, out_victim, out_wait_ns);
        end
      end
    end
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  stim_row_t stim_table[$];

  function automatic void add_row(logic op, logic [1:0] w, logic [1:0] p, logic [15:0] tid,
                                  bit typed = 1'b0, logic [2:0] st = '0, logic [15:0] ft = '0,
                                  logic [1:0] vic = '0, logic [20:0] wt = '0);
    stim_row_t row;
    row.req = '{op: op, worker: w, prio: p, task_id: tid};
    row.typed = typed;
    row.res = '{status: st, task_id: ft, victim: vic, wait_ns: wt};
    stim_table.push_back(row);
  endfunction

  initial begin
    request_t r;
    logic [2:0] counts [6];
    for (int q = 0; q < NW*NP; q++) begin
      ring_top[q] = '0;
      ring_bot[q] = '0;
    end
    for (int w = 0; w < NW; w++) begin
      fail_count[w] = '0;
      wait_step[w] = BACKOFF_START;
    end
    active_reg = 3'd4;
    counts = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};

    add_row(OP_FETCH, 2'd0, 2'd0, 16'h0000, 1, ST_NONE);          // empty after reset
    add_row(OP_PUSH,  2'd0, 2'd3, 16'hffff, 1, ST_FULL);          // bad priority
    add_row(OP_PUSH,  2'd0, 2'd0, 16'hffff, 1, ST_PUSHED);
    add_row(OP_PUSH,  2'd0, 2'd2, 16'h0000, 1, ST_PUSHED);
    add_row(OP_PUSH,  2'd1, 2'd1, 16'h5a5a, 1, ST_PUSHED);
    add_row(OP_PUSH,  2'd0, 2'd1, 16'h1234, 1, ST_PUSHED);
    add_row(OP_FETCH, 2'd0, 2'd3, 16'hbeef, 1, ST_OWN, 16'hffff, 2'd0);
    add_row(OP_FETCH, 2'd0, 2'd0, 16'h0000);
    add_row(OP_FETCH, 2'd0, 2'd0, 16'h0000);
    add_row(OP_FETCH, 2'd0, 2'd0, 16'h0000, 1, ST_STOLEN, 16'h5a5a, 2'd1);
    add_row(OP_PUSH,  2'd3, 2'd0, 16'ha5a5);
    add_row(OP_PUSH,  2'd3, 2'd0, 16'h0001);
    add_row(OP_FETCH, 2'd2, 2'd0, 16'h0000, 1, ST_STOLEN, 16'ha5a5, 2'd3);
    add_row(OP_FETCH, 2'd3, 2'd0, 16'h0000);                       // pops the last one
    // worker 1 fails until backoff starts (more than twice the worker count)
    for (int i = 0; i < 8; i++) add_row(OP_FETCH, 2'd1, 2'd0, 16'h0000, 1, ST_NONE);
    add_row(OP_FETCH, 2'd1, 2'd0, 16'h0000, 1, ST_NONE, 16'h0, 2'd0, 21'd100);
    add_row(OP_FETCH, 2'd1, 2'd0, 16'h0000, 1, ST_NONE, 16'h0, 2'd0, 21'd200);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) issue_request(stim_table[i].req, stim_table[i].typed, stim_table[i].res);

    // random phases over several worker counts, including 0 and out-of-range 7
    for (int k = 0; k < 6; k++) begin
      write_active_workers(counts[k]);
      repeat (40) random_request($urandom_range(35, 65));
    end

    // fill one deque past full, then drain it with fetches from random workers
    write_active_workers(3'd2);
    for (int i = 0; i < 260; i++) begin
      r = '{op: OP_PUSH, worker: 2'd1, prio: 2'd1, task_id: 16'($urandom)};
      issue_request(r, 1'b0, '0);
    end
    while (tasks_queued() != 0) begin
      r = '{op: OP_FETCH, worker: 2'($urandom_range(0, 3)), prio: 2'($urandom), task_id: '0};
      issue_request(r, 1'b0, '0);
    end

    // backoff runs up to its cap with a single worker
    write_active_workers(3'd1);
    for (int i = 0; i < 28; i++) begin
      r = '{op: OP_FETCH, worker: 2'd2, prio: 2'($urandom), task_id: 16'($urandom)};
      issue_request(r, 1'b0, '0);
    end

    write_active_workers(3'd4);
    repeat (50) random_request(55);
    idling_on = 1'b0;
    repeat (50) random_request(50);

    wait_quiet();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
